/* hw/rtl/ptts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Types, command codes and constants shared by the tick task scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int PERIOD_W       = 16;
  localparam int TICK_W         = 16;
  localparam int HANDLE_W       = 8;
  localparam int FIRED_W        = 8;
  localparam int NEW_HANDLE_W   = 3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REG   = 2'd1,
    CMD_SETEN = 2'd2,
    CMD_CLEAR = 2'd3
  } ptts_cmd_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic [PERIOD_W-1:0]        period;
    logic signed [HANDLE_W-1:0] handle;
    logic                       enable;
  } ptts_in_t;

  typedef struct packed {
    logic [FIRED_W-1:0]      fired_mask;
    logic [NEW_HANDLE_W-1:0] new_handle;
    logic                    ok;
    logic [TICK_W-1:0]       tick_count;
  } ptts_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan;
    logic push;
  } ptts_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
  } ptts_sts_t;

endpackage

/* hw/rtl/ptts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: accepts an item, runs the command and, for a tick, the slot
// scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ptts_ctrl
  import ptts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ptts_sts_t sts,
  output ptts_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   can_push;

  assign can_push = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    case (state_r)
      S_IDLE: begin
        ctl.load_item = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.is_tick ? S_SCAN : S_PUSH;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (can_push) begin
          ctl.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/ptts_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_dp
// Slot table, tick counter and result registers; the slot scan reads one
// entry a cycle and writes it back in the next.
// ----------------------------------------------------------------------------
module ptts_dp
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ptts_in_t  in_data,
  output ptts_out_t out_data,
  input  ptts_ctl_t ctl,
  output ptts_sts_t sts
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam int ENT_W  = 2 * PERIOD_W;

  // entry is {period, countdown}
  logic [ENT_W-1:0]        slot_mem [TASK_SLOTS];

  ptts_in_t                item_r;
  logic [CNT_W-1:0]        used_r;
  logic [TASK_SLOTS-1:0]   en_r;
  logic [TICK_W-1:0]       ticks_r;
  logic [CNT_W-1:0]        scan_idx_r;
  logic                    pipe_vld_r;
  logic [SLOT_W-1:0]       pipe_idx_r;
  logic [ENT_W-1:0]        rd_q_r;
  logic [FIRED_W-1:0]      fired_r;
  logic [NEW_HANDLE_W-1:0] newh_r;
  logic                    ok_r;
  ptts_out_t               out_r;

  logic                    reg_ok;
  logic                    set_ok;
  logic [HANDLE_W-1:0]     hraw;
  logic                    rd_en;
  logic [PERIOD_W-1:0]     wb_p;
  logic [PERIOD_W-1:0]     wb_cd;
  logic [PERIOD_W-1:0]     wb_dec;
  logic                    wb_en;
  logic                    wb_fire;
  logic [FIRED_W-1:0]      fire_bits;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_wa;
  logic [ENT_W-1:0]        mem_wd;

  assign hraw   = item_r.handle;
  assign reg_ok = (item_r.cmd == CMD_REG) && (item_r.period != '0) &&
                  (used_r < CNT_W'(TASK_SLOTS));
  // negative handles are ignored
  assign set_ok = (item_r.cmd == CMD_SETEN) && !hraw[HANDLE_W-1] &&
                  (hraw < HANDLE_W'(used_r));

  assign rd_en = ctl.scan && (scan_idx_r < used_r);

  assign wb_p    = rd_q_r[ENT_W-1:PERIOD_W];
  assign wb_cd   = rd_q_r[PERIOD_W-1:0];
  assign wb_dec  = (wb_cd != '0) ? wb_cd - 1'b1 : wb_cd;
  assign wb_en   = pipe_vld_r && en_r[pipe_idx_r];
  assign wb_fire = wb_en && (wb_dec == '0);

  always_comb begin
    fire_bits = '0;
    for (int b = 0; b < FIRED_W; b++) begin
      if ((b < TASK_SLOTS) && (pipe_idx_r == SLOT_W'(b))) begin
        fire_bits[b] = wb_fire;
      end
    end
  end

  // scan write-back and register never fall in the same cycle
  always_comb begin
    if (pipe_vld_r) begin
      mem_we = wb_en;
      mem_wa = pipe_idx_r;
      mem_wd = {wb_p, (wb_fire ? wb_p : wb_dec)};
    end else begin
      mem_we = ctl.exec && reg_ok;
      mem_wa = used_r[SLOT_W-1:0];
      mem_wd = {item_r.period, item_r.period};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r <= slot_mem[scan_idx_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      en_r       <= '0;
      ticks_r    <= '0;
      scan_idx_r <= '0;
      pipe_vld_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        scan_idx_r <= '0;
        pipe_vld_r <= 1'b0;
        case (item_r.cmd)
          CMD_TICK: begin
            ticks_r <= ticks_r + 1'b1;
          end
          CMD_REG: begin
            if (reg_ok) begin
              en_r[used_r[SLOT_W-1:0]] <= 1'b1;
              used_r                   <= used_r + 1'b1;
            end
          end
          CMD_SETEN: begin
            if (set_ok) begin
              en_r[hraw[SLOT_W-1:0]] <= item_r.enable;
            end
          end
          CMD_CLEAR: begin
            used_r  <= '0;
            en_r    <= '0;
            ticks_r <= '0;
          end
          default: begin
          end
        endcase
      end else if (ctl.scan) begin
        pipe_vld_r <= rd_en;
        if (rd_en) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end else begin
        pipe_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_r <= in_data;
    end
    if (rd_en) begin
      pipe_idx_r <= scan_idx_r[SLOT_W-1:0];
    end
    if (ctl.exec) begin
      fired_r <= '0;
      newh_r  <= reg_ok ? NEW_HANDLE_W'(used_r) : '0;
      case (item_r.cmd)
        CMD_TICK:  ok_r <= 1'b1;
        CMD_REG:   ok_r <= reg_ok;
        CMD_SETEN: ok_r <= set_ok;
        CMD_CLEAR: ok_r <= 1'b1;
        default:   ok_r <= 1'b0;
      endcase
    end else if (wb_fire) begin
      fired_r <= fired_r | fire_bits;
    end
    if (ctl.push) begin
      out_r.fired_mask <= fired_r;
      out_r.new_handle <= newh_r;
      out_r.ok         <= ok_r;
      out_r.tick_count <= ticks_r;
    end
  end

  assign sts.is_tick   = (item_r.cmd == CMD_TICK);
  assign sts.scan_done = (scan_idx_r == used_r) && !pipe_vld_r;
  assign out_data      = out_r;

endmodule

/* hw/rtl/periodic_task_tick_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Table of periodic tasks: register, enable, clear, and a tick that counts
// every enabled slot down and reports the slots that fired.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  ptts_in_t  (cmd, period, handle, enable)
//   out_     out  out_valid/out_stall ptts_out_t (fired_mask, new_handle, ok,
//                                               tick_count)
//
// register, set enable and clear run the execute state, then the push state.
// a tick runs the slot scan between them: the slot table has one read and
// one write port, so the scan visits one slot a cycle, read then write-back,
// and ends once the last write-back has drained.
// synchronous active-low reset empties the table and zeroes the tick count.
// a new item is taken while the previous result waits in the output register;
// a stalled output holds the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ptts_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ptts_out_t out_data
);

  ptts_ctl_t ctl;
  ptts_sts_t sts;

  ptts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  ptts_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .ctl      (ctl),
    .sts      (sts)
  );

endmodule
